// ===== hw/rtl/slm_pkg.sv =====
`default_nettype none
package slm_pkg;

	localparam int LIST_DEPTH = 32;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int TOT_W      = $clog2(2 * LIST_DEPTH + 1);
	localparam int DATA_W     = 32;

	typedef enum logic [1:0] {
		MODE_LOAD_A = 2'd0,
		MODE_LOAD_B = 2'd1,
		MODE_MERGE  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_RUN
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/slm_list_ram.sv =====
`default_nettype none
// One list store: single write port, single read port, registered read data.
module slm_list_ram (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic [slm_pkg::IDX_W-1:0]         waddr,
	input  wire logic signed [slm_pkg::DATA_W-1:0] wdata,
	input  wire logic [slm_pkg::IDX_W-1:0]         raddr,
	output logic signed [slm_pkg::DATA_W-1:0]      rdata
);

	logic signed [slm_pkg::DATA_W-1:0] mem [slm_pkg::LIST_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_list_merge.sv =====
// Loads (modes 0/1) write one list entry each; a new transaction is accepted every cycle while idle.
// Merge: a prime state reads both list heads, then one result per cycle while
// out_stall is low; the first result passes the prime and run states into the output register.
// in_stall stays high from the merge until the final result is registered,
// so a merge holds the input through the prime state (memory read) and the whole run.
// Reset clears both counts (lists empty); list contents are not cleared, no sweep.
`default_nettype none
module sorted_list_merge (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        mode,
	input  wire logic signed [slm_pkg::DATA_W-1:0] value,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [slm_pkg::DATA_W-1:0]      merged_value,
	output logic                                   last
);

	slm_pkg::state_t state_q, state_nxt;

	// list fill levels (0..LIST_DEPTH)
	logic [slm_pkg::CNT_W-1:0] cnt_a_q, cnt_b_q;
	// merge read pointers: index of the current head of each list
	logic [slm_pkg::CNT_W-1:0] ia_q, ib_q, ia_nxt, ib_nxt;
	// values still to emit in this run
	logic [slm_pkg::TOT_W-1:0] remain_q;

	logic in_accept;
	logic out_free;
	logic emit;
	logic take_a;
	logic a_left, b_left;
	logic we_a, we_b;
	logic is_load_a, is_load_b, is_merge;
	logic signed [slm_pkg::DATA_W-1:0] head_a, head_b;

	logic                              out_valid_q;
	logic signed [slm_pkg::DATA_W-1:0] merged_value_q;
	logic                              last_q;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// mode decode
	always_comb begin
		is_load_a = 1'b0;
		is_load_b = 1'b0;
		is_merge  = 1'b0;
		unique case (slm_pkg::mode_t'(mode))
			slm_pkg::MODE_LOAD_A: is_load_a = 1'b1;
			slm_pkg::MODE_LOAD_B: is_load_b = 1'b1;
			slm_pkg::MODE_MERGE:  is_merge  = 1'b1;
			default: ; // unused mode: ignored
		endcase
	end

	// drop loads into a full list
	assign we_a = in_accept && is_load_a
		&& (cnt_a_q < slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH));
	assign we_b = in_accept && is_load_b
		&& (cnt_b_q < slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH));

	// B wins ties: A only when strictly smaller
	assign a_left = ia_q < cnt_a_q;
	assign b_left = ib_q < cnt_b_q;
	assign take_a = a_left && (!b_left || (head_a < head_b));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			slm_pkg::ST_IDLE: begin
				if (in_accept && is_merge && ((cnt_a_q != '0) || (cnt_b_q != '0))) begin
					state_nxt = slm_pkg::ST_PRIME;
				end
			end
			slm_pkg::ST_PRIME: state_nxt = slm_pkg::ST_RUN;
			slm_pkg::ST_RUN: begin
				if (out_free && (remain_q == slm_pkg::TOT_W'(1))) begin
					state_nxt = slm_pkg::ST_IDLE;
				end
			end
			default: state_nxt = slm_pkg::ST_IDLE;
		endcase
	end

	// state outputs: read addressing and emit
	always_comb begin
		in_stall = 1'b1;
		emit     = 1'b0;
		ia_nxt   = '0;
		ib_nxt   = '0;
		unique case (state_q)
			slm_pkg::ST_IDLE:  in_stall = 1'b0;
			slm_pkg::ST_PRIME: ;
			slm_pkg::ST_RUN: begin
				emit   = out_free;
				ia_nxt = ia_q + slm_pkg::CNT_W'(out_free && take_a);
				ib_nxt = ib_q + slm_pkg::CNT_W'(out_free && !take_a);
			end
			default: ;
		endcase
	end

	// read address follows the next head so data lines up with ia_q / ib_q
	slm_list_ram u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[slm_pkg::IDX_W-1:0]),
		.wdata (value),
		.raddr (ia_nxt[slm_pkg::IDX_W-1:0]),
		.rdata (head_a)
	);

	slm_list_ram u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[slm_pkg::IDX_W-1:0]),
		.wdata (value),
		.raddr (ib_nxt[slm_pkg::IDX_W-1:0]),
		.rdata (head_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= slm_pkg::ST_IDLE;
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			ia_q     <= '0;
			ib_q     <= '0;
			remain_q <= '0;
		end else begin
			state_q <= state_nxt;
			ia_q    <= ia_nxt;
			ib_q    <= ib_nxt;
			if (we_a) begin
				cnt_a_q <= cnt_a_q + slm_pkg::CNT_W'(1);
			end
			if (we_b) begin
				cnt_b_q <= cnt_b_q + slm_pkg::CNT_W'(1);
			end
			if (state_q == slm_pkg::ST_PRIME) begin
				remain_q <= slm_pkg::TOT_W'(cnt_a_q) + slm_pkg::TOT_W'(cnt_b_q);
			end else if (emit) begin
				remain_q <= remain_q - slm_pkg::TOT_W'(1);
				// run done: both lists empty again
				if (remain_q == slm_pkg::TOT_W'(1)) begin
					cnt_a_q <= '0;
					cnt_b_q <= '0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			merged_value_q <= take_a ? head_a : head_b;
			last_q         <= (remain_q == slm_pkg::TOT_W'(1));
		end
	end

	assign out_valid    = out_valid_q;
	assign merged_value = merged_value_q;
	assign last         = last_q;

endmodule
`default_nettype wire

// ===== tb/sv/merge_checker.sv =====
`timescale 1ns / 1ps
module merge_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic [1:0]                        mode,
	input  wire logic signed [slm_pkg::DATA_W-1:0] value,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic signed [slm_pkg::DATA_W-1:0] merged_value,
	input  wire logic                              last,
	output int                                     mismatches,
	output int                                     outstanding
);

	typedef struct packed {
		logic signed [slm_pkg::DATA_W-1:0] val;
		logic                              fin;
	} merged_t;

	logic signed [slm_pkg::DATA_W-1:0] held_a[$];
	logic signed [slm_pkg::DATA_W-1:0] held_b[$];
	merged_t                           awaited[$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	// two-way merge of the held lists; B wins ties, then lists are emptied
	function automatic void predict_merge();
		int      ia;
		int      ib;
		int      total;
		merged_t item;
		ia    = 0;
		ib    = 0;
		total = held_a.size() + held_b.size();
		while (ia + ib < total) begin
			if (ib >= held_b.size() || (ia < held_a.size() && held_a[ia] < held_b[ib])) begin
				item.val = held_a[ia];
				ia++;
			end else begin
				item.val = held_b[ib];
				ib++;
			end
			item.fin = (ia + ib == total);
			awaited.insert(awaited.size(), item);
		end
		held_a.delete();
		held_b.delete();
	endfunction

	always @(posedge clk) begin
		merged_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					mismatches++;
					$display("%0t: result %0d last %0b arrived, expected none",
						$time, merged_value, last);
				end else begin
					want = awaited.pop_front();
					if (merged_value !== want.val) begin
						mismatches++;
						$display("%0t: merged_value expected %0d actual %0d",
							$time, want.val, merged_value);
					end
					if (last !== want.fin) begin
						mismatches++;
						$display("%0t: last expected %0b actual %0b",
							$time, want.fin, last);
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (mode)
					slm_pkg::MODE_LOAD_A:
						if (held_a.size() < slm_pkg::LIST_DEPTH)
							held_a.insert(held_a.size(), value);
					slm_pkg::MODE_LOAD_B:
						if (held_b.size() < slm_pkg::LIST_DEPTH)
							held_b.insert(held_b.size(), value);
					slm_pkg::MODE_MERGE:  predict_merge();
					default:              ;
				endcase
			end
		end
		outstanding <= awaited.size();
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

	// mode 3 has no meaning in the block; it must be swallowed silently
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic signed [slm_pkg::DATA_W-1:0] VAL_MIN =
		{1'b1, {(slm_pkg::DATA_W-1){1'b0}}};
	localparam logic signed [slm_pkg::DATA_W-1:0] VAL_MAX =
		{1'b0, {(slm_pkg::DATA_W-1){1'b1}}};

	localparam int ITEM_TARGET  = 280;   // stop issuing batches past this many transactions
	localparam int QUIET_FROM   = 235;   // no idling on either side from here on
	localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction before giving up
	localparam int DRAIN_CYCLES = 8;

	logic                              clk          = 1'b0;
	logic                              arst_n       = 1'b0;
	logic                              in_valid     = 1'b0;
	logic [1:0]                        mode         = slm_pkg::MODE_LOAD_A;
	logic signed [slm_pkg::DATA_W-1:0] value        = '0;
	logic                              out_stall    = 1'b0;
	logic                              in_stall;
	logic                              out_valid;
	logic signed [slm_pkg::DATA_W-1:0] merged_value;
	logic                              last;

	int mismatches;
	int outstanding;

	int sent       = 0;   // transactions with a defined mode
	int gap_odds   = 1;   // sender gap chance, in eighths
	int stall_odds = 0;   // receiver stall chance, in eighths
	int stall_left = 0;
	int cycle_no   = 0;

	wire quiet = (sent >= QUIET_FROM);

	sorted_list_merge dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.merged_value (merged_value),
		.last         (last)
	);

	merge_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.merged_value (merged_value),
		.last         (last),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Receiver back-pressure: stall bursts of random length, none once quiet. The burst
	// rate (0..3 eighths) is re-rolled periodically, and a rate of zero gives long clean stretches.
	always @(posedge clk) begin
		cycle_no++;
		if (cycle_no % 48 == 0) stall_odds = $urandom_range(0, 3);
		if (quiet) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 7) < stall_odds) begin
			stall_left = $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: a run that stops moving transactions for too long is a hang.
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
			else idle++;
		end
		$display("sorted_list_merge verification failed");
		$finish;
	end

	// One input transaction. An optional idle burst goes first; valid then
	// stays high until the block takes it. Called at a rising edge only, so
	// every drive lands as a nonblocking update at the clock edge.
	task automatic send_txn(input logic [1:0] m,
		input logic signed [slm_pkg::DATA_W-1:0] v);
		int gap;
		if (!quiet && $urandom_range(0, 7) < gap_odds) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		value    <= v;
		do @(posedge clk); while (in_stall);
		if (m != MODE_UNUSED) sent++;
	endtask

	// Next list element. Wide lists climb from a random start by large steps
	// and pin at the top of the range; narrow lists sit around zero so ties
	// across A and B are common; style 2 is unsorted noise.
	function automatic logic signed [slm_pkg::DATA_W-1:0] next_elem(
		input logic signed [slm_pkg::DATA_W-1:0] prev, input bit first, input int style);
		longint t;
		case (style)
			0: begin
				if (first) return $urandom;
				t = longint'(prev) + longint'($urandom_range(0, 32'h0fff_ffff));
				return (t > longint'(VAL_MAX)) ? VAL_MAX : slm_pkg::DATA_W'(t);
			end
			1: begin
				if (first) return int'($urandom_range(0, 6)) - 3;
				return prev + int'($urandom_range(0, 1));
			end
			default: return $urandom;
		endcase
	endfunction

	// Mostly short lists, now and then a long one, rarely past the depth.
	function automatic int pick_len();
		int roll;
		roll = $urandom_range(0, 24);
		if (roll < 19) return $urandom_range(0, 6);
		if (roll < 24) return $urandom_range(7, 32);
		return $urandom_range(33, 36);
	endfunction

	function automatic int pick_style();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6) return 0;
		if (roll < 9) return 1;
		return 2;
	endfunction

	// One well-formed batch: loads of A and B interleaved at random, stray
	// mode-3 transactions mixed in, closed by a merge.
	task automatic run_batch(input int na, input int nb, input int style);
		int                                la;
		int                                lb;
		logic signed [slm_pkg::DATA_W-1:0] cur_a;
		logic signed [slm_pkg::DATA_W-1:0] cur_b;
		la    = 0;
		lb    = 0;
		cur_a = '0;
		cur_b = '0;
		while (la < na || lb < nb) begin
			if ($urandom_range(0, 29) == 0) send_txn(MODE_UNUSED, $urandom);
			if (lb >= nb || (la < na && $urandom_range(0, 1) == 0)) begin
				cur_a = next_elem(cur_a, la == 0, style);
				send_txn(slm_pkg::MODE_LOAD_A, cur_a);
				la++;
			end else begin
				cur_b = next_elem(cur_b, lb == 0, style);
				send_txn(slm_pkg::MODE_LOAD_B, cur_b);
				lb++;
			end
		end
		send_txn(slm_pkg::MODE_MERGE, $urandom);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// merge with nothing loaded, then an undefined mode with all value bits set
		send_txn(slm_pkg::MODE_MERGE, $urandom);
		send_txn(MODE_UNUSED, '1);

		// range extremes, equal heads at both ends (B must win each tie)
		send_txn(slm_pkg::MODE_LOAD_A, VAL_MIN);
		send_txn(slm_pkg::MODE_LOAD_B, VAL_MIN);
		send_txn(slm_pkg::MODE_LOAD_A, -1);
		send_txn(slm_pkg::MODE_LOAD_B, 0);
		send_txn(slm_pkg::MODE_LOAD_A, VAL_MAX);
		send_txn(slm_pkg::MODE_LOAD_B, VAL_MAX);
		send_txn(slm_pkg::MODE_MERGE, $urandom);

		// unsorted A: the merge rule runs on stored order, no reordering
		send_txn(slm_pkg::MODE_LOAD_A, 5);
		send_txn(slm_pkg::MODE_LOAD_A, -3);
		send_txn(slm_pkg::MODE_LOAD_B, 1);
		send_txn(slm_pkg::MODE_MERGE, $urandom);

		// only B loaded, then only A loaded
		send_txn(slm_pkg::MODE_LOAD_B, -1);
		send_txn(slm_pkg::MODE_LOAD_B, -2);
		send_txn(slm_pkg::MODE_MERGE, $urandom);
		send_txn(slm_pkg::MODE_LOAD_A, 7);
		send_txn(slm_pkg::MODE_MERGE, $urandom);

		// undefined mode between a load and its merge leaves the list alone
		send_txn(slm_pkg::MODE_LOAD_A, 9);
		send_txn(MODE_UNUSED, 0);
		send_txn(slm_pkg::MODE_MERGE, $urandom);
		send_txn(slm_pkg::MODE_MERGE, $urandom);

		// hold the input until the merges above have fully drained
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);

		// both lists overfilled: extra loads are dropped, 64-value merge run
		run_batch(slm_pkg::LIST_DEPTH + 2, slm_pkg::LIST_DEPTH + 1, 0);

		while (sent < ITEM_TARGET) begin
			gap_odds = $urandom_range(0, 3);
			run_batch(pick_len(), pick_len(), pick_style());
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("sorted_list_merge verification clean");
		end else begin
			$display("sorted_list_merge verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/slm_pkg.sv
hw/rtl/slm_list_ram.sv
hw/rtl/sorted_list_merge.sv
tb/sv/merge_checker.sv
tb/sv/testbench.sv
